// ----- sv/pdg_pkg.sv -----
package pdg_pkg;

  localparam int COORD_W = 16;
  localparam int QUOTA_W = 13;
  localparam int DIST_W = 33;
  localparam int QUO_W = 12;
  localparam int CS_MIN = 16;
  localparam int QUOTA_MAX = 4096;
  localparam int SCAN_CELLS = 25;
  localparam int SCAN_DRAIN = 3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_CAND  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_CELL_SIZE   = 2'd0,
    REG_GRID_COLS   = 2'd1,
    REG_GRID_ROWS   = 2'd2,
    REG_MIN_DIST_SQ = 2'd3
  } reg_idx_t;

endpackage

// ----- sv/pdg_div.sv -----
module pdg_div
  import pdg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [COORD_W-1:0] num_x,
  input  logic [COORD_W-1:0] num_y,
  input  logic [COORD_W-1:0] divisor,
  output logic               done,
  output logic [QUO_W-1:0]   quo_x,
  output logic [QUO_W-1:0]   quo_y
);

  logic                       run;
  logic [$clog2(COORD_W)-1:0] cnt;
  logic [COORD_W-1:0]         sx;
  logic [COORD_W-1:0]         sy;
  logic [COORD_W-1:0]         rx;
  logic [COORD_W-1:0]         ry;
  logic [COORD_W:0]           rx_sh;
  logic [COORD_W:0]           ry_sh;
  logic                       bx;
  logic                       by;

  // Restoring division, one quotient bit per cycle for both coordinates.
  always_comb begin
    rx_sh = {rx, sx[COORD_W-1]};
    ry_sh = {ry, sy[COORD_W-1]};
    bx = rx_sh >= {1'b0, divisor};
    by = ry_sh >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      if (go) begin
        run <= 1'b1;
        done <= 1'b0;
        cnt <= '0;
        sx <= num_x;
        sy <= num_y;
        rx <= '0;
        ry <= '0;
      end else if (run) begin
        rx <= bx ? COORD_W'(rx_sh - {1'b0, divisor}) : rx_sh[COORD_W-1:0];
        ry <= by ? COORD_W'(ry_sh - {1'b0, divisor}) : ry_sh[COORD_W-1:0];
        sx <= {sx[COORD_W-2:0], bx};
        sy <= {sy[COORD_W-2:0], by};
        cnt <= cnt + 1'b1;
        done <= (cnt == '1);
        if (cnt == '1) begin
          run <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  // The divisor is at least 16 (CS_MIN), so the quotient fits in the low bits.
  assign quo_x = sx[QUO_W-1:0];
  assign quo_y = sy[QUO_W-1:0];

endmodule

// ----- sv/poisson_disk_grid_accept.sv -----
// Channel | Dir | Handshake           | Payload
// s_*     | in  | s_tvalid / s_tready | tdata: quota, cand_x, cand_y; tuser: op
// m_*     | out | m_tvalid / m_tready | tdata: accepted, point_x, point_y, placed_count, done_res
// apb     | in  | psel & penable      | 64-bit registers at byte address 8*i
//
// A candidate passes through the bit-serial cell division, 25 grid memory reads
// (one per neighbor cell on the single read port) and a 3-stage drain.
// A start item sweeps all GRID_DIM*GRID_DIM grid memory entries, one entry a cycle.
// After reset the same clearing sweep runs before the first item is taken.
// A finished result waits in the output register; the next item is taken meanwhile.
module poisson_disk_grid_accept
  import pdg_pkg::*;
#(
  parameter int GRID_DIM = 64,
  parameter int ATTEMPTS_PER_POINT = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // quota[12:0], cand_x[28:13], cand_y[44:29]
  input  logic        s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // accepted[0], point_x[16:1], point_y[32:17],
                                // placed_count[45:33], done_res[46]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int DEPTH = GRID_DIM * GRID_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int DW = $clog2(GRID_DIM + 1);
  localparam int NW = CW + 3;
  localparam int AT_W = $clog2(QUOTA_MAX * ATTEMPTS_PER_POINT + 1);
  localparam int EW = 2 * COORD_W + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DIV, ST_SCAN, ST_WRITE, ST_RES
  } state_t;

  state_t state;

  logic [COORD_W-1:0] cell_size;
  logic [6:0]         grid_cols;
  logic [6:0]         grid_rows;
  logic [DIST_W-1:0]  min_dist_sq;

  logic [QUOTA_W-1:0] quota_left;
  logic [AT_W-1:0]    attempts_left;
  logic [QUOTA_W-1:0] placed;
  logic               pend_res;
  logic               acc;
  logic               rej;
  logic [COORD_W-1:0] x_r;
  logic [COORD_W-1:0] y_r;
  logic [CW-1:0]      cx;
  logic [CW-1:0]      cy;
  logic [AW-1:0]      clr_cnt;
  logic [4:0]         sc;
  logic [2:0]         sx;
  logic [2:0]         sy;

  logic [EW-1:0]      mem [DEPTH];
  logic [EW-1:0]      rdata;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [EW-1:0]      wdata;
  logic [AW-1:0]      raddr;

  logic               v1;
  logic               v2;
  logic               v3;
  logic [COORD_W-1:0] ddx;
  logic [COORD_W-1:0] ddy;
  logic [2*COORD_W-1:0] sqx;
  logic [2*COORD_W-1:0] sqy;

  logic               div_go;
  logic               div_done;
  logic [QUO_W-1:0]   quo_x;
  logic [QUO_W-1:0]   quo_y;

  logic [COORD_W-1:0] cs_eff;
  logic [DW-1:0]      cols_eff;
  logic [DW-1:0]      rows_eff;
  logic [NW-1:0]      nx;
  logic [NW-1:0]      ny;
  logic               issuing;
  logic               in_range;
  logic               region_done;
  logic [QUOTA_W-1:0] q_in;
  logic [QUOTA_W-1:0] q_sat;
  logic               cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= COORD_W'(CS_MIN);
      grid_cols <= 7'd1;
      grid_rows <= 7'd1;
      min_dist_sq <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:3]))
        REG_CELL_SIZE:   cell_size <= pwdata[COORD_W-1:0];
        REG_GRID_COLS:   grid_cols <= pwdata[6:0];
        REG_GRID_ROWS:   grid_rows <= pwdata[6:0];
        REG_MIN_DIST_SQ: min_dist_sq <= pwdata[DIST_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:3]))
      REG_CELL_SIZE:   prdata = 64'(cell_size);
      REG_GRID_COLS:   prdata = 64'(grid_cols);
      REG_GRID_ROWS:   prdata = 64'(grid_rows);
      REG_MIN_DIST_SQ: prdata = 64'(min_dist_sq);
      default:         prdata = '0;
    endcase
  end

  // Effective grid geometry.
  always_comb begin
    cs_eff = (cell_size < COORD_W'(CS_MIN)) ? COORD_W'(CS_MIN) : cell_size;
    if (grid_cols == 7'd0) cols_eff = DW'(1);
    else if (9'(grid_cols) > 9'(GRID_DIM)) cols_eff = DW'(GRID_DIM);
    else cols_eff = DW'(grid_cols);
    if (grid_rows == 7'd0) rows_eff = DW'(1);
    else if (9'(grid_rows) > 9'(GRID_DIM)) rows_eff = DW'(GRID_DIM);
    else rows_eff = DW'(grid_rows);
  end

  assign region_done = (quota_left == '0) || (attempts_left == '0);
  assign q_in = s_tdata[QUOTA_W-1:0];
  assign q_sat = (q_in > QUOTA_W'(QUOTA_MAX)) ? QUOTA_W'(QUOTA_MAX) : q_in;
  assign s_tready = (state == ST_IDLE);

  // Neighbor cell for the current scan step; negative offsets wrap into the top bit.
  always_comb begin
    nx = NW'(cx) + NW'(sx) - NW'(2);
    ny = NW'(cy) + NW'(sy) - NW'(2);
    issuing = (state == ST_SCAN) && (sc < 5'(SCAN_CELLS));
    in_range = !nx[NW-1] && !ny[NW-1] && (nx < NW'(cols_eff)) && (ny < NW'(rows_eff));
    raddr = AW'(ny[CW-1:0]) * AW'(GRID_DIM) + AW'(nx[CW-1:0]);
  end

  always_comb begin
    we = 1'b0;
    waddr = clr_cnt;
    wdata = '0;
    if (state == ST_CLEAR) begin
      we = 1'b1;
    end else if (state == ST_WRITE && !rej) begin
      we = 1'b1;
      waddr = AW'(cy) * AW'(GRID_DIM) + AW'(cx);
      wdata = {1'b1, x_r, y_r};
    end
  end

  // Grid memory: valid bit, x, y.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  pdg_div u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .num_x   (x_r),
    .num_y   (y_r),
    .divisor (cs_eff),
    .done    (div_done),
    .quo_x   (quo_x),
    .quo_y   (quo_y)
  );

  // Distance pipeline: memory data, absolute differences, squares, compare.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= issuing && in_range;
      v2 <= v1 && rdata[EW-1];
      v3 <= v2;
    end
    ddx <= (rdata[EW-2:COORD_W] > x_r) ? rdata[EW-2:COORD_W] - x_r
                                       : x_r - rdata[EW-2:COORD_W];
    ddy <= (rdata[COORD_W-1:0] > y_r) ? rdata[COORD_W-1:0] - y_r
                                      : y_r - rdata[COORD_W-1:0];
    sqx <= ddx * ddx;
    sqy <= ddy * ddy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_cnt <= '0;
      pend_res <= 1'b0;
      quota_left <= '0;
      attempts_left <= '0;
      placed <= '0;
      m_tvalid <= 1'b0;
      div_go <= 1'b0;
      rej <= 1'b0;
      acc <= 1'b0;
      sc <= '0;
      sx <= '0;
      sy <= '0;
    end else begin
      div_go <= (state == ST_IDLE) && s_tvalid && (op_t'(s_tuser) == OP_CAND) &&
                !region_done;
      if (m_tready && state != ST_RES) m_tvalid <= 1'b0;
      if (v3 && ({1'b0, sqx} + {1'b0, sqy} < min_dist_sq)) rej <= 1'b1;
      unique case (state)
        ST_CLEAR: begin
          if (clr_cnt == AW'(DEPTH - 1)) begin
            clr_cnt <= '0;
            state <= pend_res ? ST_RES : ST_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            acc <= 1'b0;
            if (op_t'(s_tuser) == OP_START) begin
              quota_left <= q_sat;
              attempts_left <= AT_W'(q_sat) * AT_W'(ATTEMPTS_PER_POINT);
              placed <= '0;
              x_r <= '0;
              y_r <= '0;
              pend_res <= 1'b1;
              state <= ST_CLEAR;
            end else begin
              x_r <= s_tdata[QUOTA_W+COORD_W-1:QUOTA_W];
              y_r <= s_tdata[QUOTA_W+2*COORD_W-1:QUOTA_W+COORD_W];
              if (region_done) begin
                state <= ST_RES;
              end else begin
                attempts_left <= attempts_left - 1'b1;
                state <= ST_DIV;
              end
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            cx <= (13'(quo_x) > 13'(cols_eff) - 13'd1) ? CW'(cols_eff - 1'b1) : CW'(quo_x);
            cy <= (13'(quo_y) > 13'(rows_eff) - 13'd1) ? CW'(rows_eff - 1'b1) : CW'(quo_y);
            sc <= '0;
            sx <= '0;
            sy <= '0;
            rej <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          sc <= sc + 1'b1;
          if (issuing) begin
            if (sx == 3'd4) begin
              sx <= '0;
              sy <= sy + 1'b1;
            end else begin
              sx <= sx + 1'b1;
            end
          end
          if (sc == 5'(SCAN_CELLS + SCAN_DRAIN - 1)) state <= ST_WRITE;
        end
        ST_WRITE: begin
          if (!rej) begin
            quota_left <= quota_left - 1'b1;
            placed <= placed + 1'b1;
            acc <= 1'b1;
          end
          state <= ST_RES;
        end
        ST_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, region_done, placed, y_r, x_r, acc};
            pend_res <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_placed_bound: assert property (@(posedge clk) disable iff (rst)
    placed <= QUOTA_W'(QUOTA_MAX))
    else $error("placed count above quota limit");

  a_attempts_down: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready && op_t'(s_tuser) == OP_START)
      |=> attempts_left <= $past(attempts_left))
    else $error("attempt budget grew without a start");

  a_place_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && !rej) |=> placed == $past(placed) + 1'b1)
    else $error("accepted point not counted");

  a_no_scan_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !we)
    else $error("grid written during neighbor scan");

endmodule

// ----- tb/sv/poisson_disk_grid_accept_tb.sv -----
module poisson_disk_grid_accept_tb;
  import pdg_pkg::*;

  typedef struct packed {
    op_t         op;
    logic [12:0] quota;
    logic [15:0] cx;
    logic [15:0] cy;
  } cand_item_t;

  typedef struct packed {
    logic        accepted;
    logic [15:0] px;
    logic [15:0] py;
    logic [12:0] placed_count;
    logic        done_res;
  } place_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [47:0] s_tdata = '0;  // quota, cand_x, cand_y from bit 0 up
  logic s_tuser = 1'b0;       // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [47:0] m_tdata;       // accepted, point_x, point_y, placed_count, done_res
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  poisson_disk_grid_accept uut (.*);

  cand_item_t pending_items[$];
  place_res_t expected_places[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Predictor state.
  logic [32:0] grid_mem[64*64];
  int unsigned quota_left, attempts_left, placed_n;
  int unsigned cur_cell, cur_cols, cur_rows;
  logic [32:0] cur_min_dsq;

  initial forever #6 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic int unsigned fix_dim(input int unsigned v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic place_res_t predict_place(input cand_item_t it);
    place_res_t r;
    int unsigned cs, cols, rows, gx, gy;
    int nx, ny;
    bit ok;
    logic [32:0] e;
    longint unsigned ddx, ddy;
    r = '0;
    if (it.op == OP_START) begin
      foreach (grid_mem[i]) grid_mem[i] = '0;
      quota_left = (it.quota > 4096) ? 4096 : it.quota;
      attempts_left = quota_left * 25;
      placed_n = 0;
      r.done_res = (quota_left == 0);
      return r;
    end
    if (quota_left != 0 && attempts_left != 0) begin
      cs = (cur_cell < 16) ? 16 : cur_cell;
      cols = fix_dim(cur_cols);
      rows = fix_dim(cur_rows);
      gx = it.cx / cs;
      if (gx > cols - 1) gx = cols - 1;
      gy = it.cy / cs;
      if (gy > rows - 1) gy = rows - 1;
      ok = 1;
      attempts_left--;
      for (int dy = -2; dy <= 2; dy++)
        for (int dx = -2; dx <= 2; dx++) begin
          nx = int'(gx) + dx;
          ny = int'(gy) + dy;
          if (nx < 0 || ny < 0 || nx >= int'(cols) || ny >= int'(rows)) continue;
          e = grid_mem[ny*64 + nx];
          if (!e[32]) continue;
          ddx = (e[31:16] > it.cx) ? e[31:16] - it.cx : it.cx - e[31:16];
          ddy = (e[15:0] > it.cy) ? e[15:0] - it.cy : it.cy - e[15:0];
          if (ddx*ddx + ddy*ddy < cur_min_dsq) ok = 0;
        end
      if (ok) begin
        grid_mem[gy*64 + gx] = {1'b1, it.cx, it.cy};
        quota_left--;
        placed_n++;
        r.accepted = 1'b1;
      end
    end
    r.px = it.cx;
    r.py = it.cy;
    r.placed_count = placed_n[12:0];
    r.done_res = (quota_left == 0 || attempts_left == 0);
    return r;
  endfunction

  // Driver: one transfer per accepted handshake.
  always @(posedge clk) begin
    cand_item_t it;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_places.push_back(predict_place({op_t'(s_tuser), s_tdata[12:0],
                                                 s_tdata[28:13], s_tdata[44:29]}));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= it.op;
          s_tdata <= {3'b0, it.cy, it.cx, it.quota};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    place_res_t got, want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = '{accepted: m_tdata[0], px: m_tdata[16:1], py: m_tdata[32:17],
                placed_count: m_tdata[45:33], done_res: m_tdata[46]};
        if (expected_places.size() == 0) begin
          report_mismatch("unexpected transfer", 64'(m_tdata), '0);
        end else begin
          want = expected_places.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
          if (got.px !== want.px) report_mismatch("point_x", 64'(got.px), 64'(want.px));
          if (got.py !== want.py) report_mismatch("point_y", 64'(got.py), 64'(want.py));
          if (got.placed_count !== want.placed_count)
            report_mismatch("placed_count", 64'(got.placed_count),
                            64'(want.placed_count));
          if (got.done_res !== want.done_res)
            report_mismatch("done_res", 64'(got.done_res), 64'(want.done_res));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CELL_SIZE:   cur_cell = val[15:0];
      REG_GRID_COLS:   cur_cols = val[6:0];
      REG_GRID_ROWS:   cur_rows = val[6:0];
      REG_MIN_DIST_SQ: cur_min_dsq = val[32:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || s_tvalid || expected_places.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic push_item(input op_t op, input int q, input int x, input int y);
    pending_items.push_back('{op: op, quota: q[12:0], cx: x[15:0], cy: y[15:0]});
  endtask

  function automatic int rand_coord(input int span);
    if ($urandom_range(9) == 0) return $urandom_range(65535);
    return $urandom_range(span);
  endfunction

  task automatic setup_phase(input int cs, input int cols, input int rows,
                             input longint unsigned dsq);
    write_reg(REG_CELL_SIZE, 64'(cs));
    write_reg(REG_GRID_COLS, 64'(cols));
    write_reg(REG_GRID_ROWS, 64'(rows));
    write_reg(REG_MIN_DIST_SQ, dsq);
  endtask

  // Well-formed regions with random points; some noise starts in between.
  task automatic random_phase(input int n_items, input int span);
    int n;
    n = 0;
    while (n < n_items) begin
      push_item(OP_START, ($urandom_range(9) == 0) ? $urandom_range(8191)
                          : $urandom_range(1, 12), 0, 0);
      n++;
      repeat ($urandom_range(5, 40)) begin
        push_item(OP_CAND, $urandom_range(8191), rand_coord(span), rand_coord(span));
        n++;
      end
    end
  endtask

  initial begin
    cur_cell = 16; cur_cols = 1; cur_rows = 1; cur_min_dsq = 0;
    quota_left = 0; attempts_left = 0; placed_n = 0;
    foreach (grid_mem[i]) grid_mem[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: candidate before any start, then reset-default registers.
    push_item(OP_CAND, 0, 16'hFFFF, 16'hFFFF);
    push_item(OP_START, 0, 0, 0);
    push_item(OP_CAND, 8191, 5, 5);
    push_item(OP_START, 2, 0, 0);
    push_item(OP_CAND, 0, 0, 0);
    push_item(OP_CAND, 0, 65535, 65535);
    push_item(OP_CAND, 0, 1, 1);
    wait_idle();
    // Tiny cell size, out-of-range grid, large spacing.
    setup_phase(3, 0, 127, 64'h1_FFFC_0002);
    push_item(OP_START, 8191, 0, 0);
    push_item(OP_CAND, 0, 0, 0);
    push_item(OP_CAND, 0, 65535, 65535);
    push_item(OP_CAND, 0, 65535, 0);
    wait_idle();
    setup_phase(65535, 64, 64, 0);
    push_item(OP_START, 4096, 0, 0);
    push_item(OP_CAND, 0, 65535, 65535);
    push_item(OP_CAND, 0, 65535, 65535);
    push_item(OP_CAND, 0, 0, 0);
    wait_idle();
    // Grid changed mid-region.
    setup_phase(16, 64, 64, 400);
    push_item(OP_START, 5, 0, 0);
    push_item(OP_CAND, 0, 100, 100);
    wait_idle();
    write_reg(REG_CELL_SIZE, 64'd40);
    push_item(OP_CAND, 0, 110, 105);
    push_item(OP_CAND, 0, 300, 300);
    wait_idle();

    setup_phase(16, 64, 64, 1600);
    random_phase(330, 1100);
    wait_idle();
    send_idle_pct = 53;
    setup_phase(100, 20, 30, 15000);
    random_phase(330, 3000);
    wait_idle();
    send_idle_pct = 0; recv_stall_pct = 53;
    setup_phase(1024, 64, 64, 64'h1_0000_0000);
    random_phase(330, 65535);
    wait_idle();
    send_idle_pct = 9; recv_stall_pct = 9;
    setup_phase(20, 7, 3, 900);
    random_phase(330, 400);
    wait_idle();

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/pdg_pkg.sv
sv/pdg_div.sv
sv/poisson_disk_grid_accept.sv
tb/sv/poisson_disk_grid_accept_tb.sv
